### rtl/core/cdd_pkg.sv
// Package with the request and result types, status codes and calendar tables.
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned DayW      = 5;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 14;
  localparam int unsigned WalkYearW = YearW + 1;
  localparam int unsigned CountW    = 22;
  localparam int unsigned StatusW   = 2;

  localparam logic [YearW-1:0]  MAX_YEAR        = YearW'(9999);
  localparam logic [MonthW-1:0] MONTHS_PER_YEAR = MonthW'(12);
  localparam logic [CountW-1:0] DAYS_PER_YEAR   = CountW'(365);

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_ORDER   = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_END = 2'd2;

  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   end_day;
    logic [MonthW-1:0] end_month;
    logic [YearW-1:0]  end_year;
  } cdd_req_t;

  typedef struct packed {
    logic [CountW-1:0]  day_count;
    logic [StatusW-1:0] status;
  } cdd_res_t;

  // Year first, so that comparing the packed words orders the dates.
  typedef struct packed {
    logic [WalkYearW-1:0] year;
    logic [MonthW-1:0]    month;
    logic [DayW-1:0]      day;
  } cdd_date_t;

  typedef struct packed {
    logic equal;
    logic end_before;
    logic year_behind;
  } cdd_flags_t;

  // Length of a month; a month outside the year has length zero.
  function automatic logic [DayW-1:0] len_of(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DayW'(30);
      4'd2:                                       len = DayW'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  function automatic logic day_month_real(input logic [DayW-1:0] d,
                                          input logic [MonthW-1:0] m);
    logic m_ok;
    m_ok = (m >= MonthW'(1)) && (m <= MONTHS_PER_YEAR);
    return m_ok && (d >= DayW'(1)) && (d <= len_of(m));
  endfunction

endpackage

### rtl/core/cdd_step.sv
// Shared date step unit: advances the working date by a day or a year and compares it.
`timescale 1ns / 1ps

module cdd_step
  import cdd_pkg::*;
(
  input  cdd_date_t         walk,
  input  cdd_date_t         end_date,
  input  logic [CountW-1:0] count,
  input  logic              year_step,
  output cdd_date_t         walk_next,
  output logic [CountW-1:0] count_next,
  output cdd_flags_t        flags
);

  logic [DayW:0]   day_inc;
  logic [MonthW:0] month_inc;
  logic            wrap_month;
  logic            wrap_year;
  cdd_date_t       year_ahead;

  always_comb begin
    day_inc    = {1'b0, walk.day} + (DayW+1)'(1);
    wrap_month = day_inc > {1'b0, len_of(walk.month)};
    month_inc  = {1'b0, walk.month} + (MonthW+1)'(wrap_month);
    wrap_year  = month_inc > {1'b0, MONTHS_PER_YEAR};

    year_ahead      = walk;
    year_ahead.year = walk.year + WalkYearW'(1);

    if (year_step) begin
      walk_next      = walk;
      walk_next.year = walk.year + WalkYearW'(1);
      count_next     = count + DAYS_PER_YEAR;
    end else begin
      walk_next.day   = wrap_month ? DayW'(1) : day_inc[DayW-1:0];
      walk_next.month = wrap_year ? MonthW'(1) : month_inc[MonthW-1:0];
      walk_next.year  = walk.year + WalkYearW'(wrap_year);
      count_next      = count + CountW'(1);
    end

    flags.equal       = walk == end_date;
    flags.end_before  = end_date < walk;
    flags.year_behind = year_ahead <= end_date;
  end

endmodule

### rtl/core/calendar_day_difference.sv
// Top level: sequencer that walks a start date to an end date on a 365-day calendar.
// After S_NORM, the result is registered in S_CHECK for an error status, and in S_WALK
// when ok, where the shared step unit advances the date by one year or one day per cycle.
// Only one request is in work at a time; busy stays high until the result is shown.
// The result is shown for exactly one cycle with done; synchronous reset returns to idle.
`timescale 1ns / 1ps

module calendar_day_difference
  import cdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cdd_req_t request,
  output logic     busy,
  output logic     done,
  output cdd_res_t result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;

  logic [2:0]        state;
  cdd_date_t         walk;
  cdd_date_t         end_date;
  logic [CountW-1:0] count;
  logic              year_step;
  cdd_date_t         walk_next;
  logic [CountW-1:0] count_next;
  cdd_flags_t        flags;
  logic              end_real;

  assign busy = state != S_IDLE;

  assign year_step = (state == S_WALK) && flags.year_behind;

  assign end_real = day_month_real(end_date.day, end_date.month)
                    && (end_date.year <= WalkYearW'(MAX_YEAR));

  cdd_step u_step (
    .walk       (walk),
    .end_date   (end_date),
    .count      (count),
    .year_step  (year_step),
    .walk_next  (walk_next),
    .count_next (count_next),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            walk.day        <= request.start_day;
            walk.month      <= request.start_month;
            walk.year       <= WalkYearW'(request.start_year);
            end_date.day    <= request.end_day;
            end_date.month  <= request.end_month;
            end_date.year   <= WalkYearW'(request.end_year);
            count           <= '0;
            state           <= S_NORM;
          end
        end
        S_NORM: begin
          if (!day_month_real(walk.day, walk.month)) begin
            walk  <= walk_next;
            count <= count_next;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!end_real) begin
            result.day_count <= '0;
            result.status    <= ST_BAD_END;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else if (flags.end_before) begin
            result.day_count <= '0;
            result.status    <= ST_ORDER;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (flags.equal) begin
            result.day_count <= count;
            result.status    <= ST_OK;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else begin
            walk  <= walk_next;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The walk never passes the end date.
  a_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !flags.end_before)
    else $error("working date passed the end date");

  // An error status always carries a zero count.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.day_count == '0))
    else $error("error result with nonzero count");

  // The result strobe coincides with the return to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while still busy");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start work");

endmodule
